[rtl/gdmm_pkg.sv]
`timescale 1ns / 1ps
// gdmm_pkg: shared types and constants of the GPS decimator with extremes.
// No dependencies.
package gdmm_pkg;

    localparam int SUM_W = 48;          // window sum accumulators
    localparam int DIV_CNT_W = 6;       // iteration counter of the divider
    localparam int MPH_W = 20;          // speed in metres per hour
    localparam int MPH_X_W = 24;        // 36 * speed + 5
    // ceil(2^27 / 10): exact quotient by ten for values below 2^26
    localparam logic [23:0] RECIP_TEN = 24'd13421773;
    localparam int RECIP_SHIFT = 27;

    localparam logic [31:0] TIME_INVALID = 32'hFFFF_FFFF;

    localparam logic [1:0] REC_SAMPLE = 2'd0;
    localparam logic [1:0] REC_MIN    = 2'd1;
    localparam logic [1:0] REC_MAX    = 2'd2;

    localparam logic [1:0] CFG_PERIOD = 2'd0;
    localparam logic [1:0] CFG_OFFSET = 2'd1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV_GS,
        ST_CONV_SS,
        ST_UPDATE,
        ST_ALT_GO,
        ST_ALT_WAIT,
        ST_GS_GO,
        ST_GS_WAIT,
        ST_SS_GO,
        ST_SS_WAIT,
        ST_EMIT,
        ST_RPT_MIN,
        ST_RPT_MAX
    } state_t;

endpackage

[rtl/gdmm_div.sv]
`timescale 1ns / 1ps
// gdmm_div: restoring divider, one quotient bit per cycle.
// Depends on gdmm_pkg.
module gdmm_div #(
    parameter int DIVISOR_W = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [gdmm_pkg::SUM_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]        divisor,
    output logic                        busy,
    output logic                        done,
    output logic [gdmm_pkg::SUM_W-1:0]  quotient
);
    localparam int W = gdmm_pkg::SUM_W;

    logic [DIVISOR_W:0]                 rem_reg, rem_next;
    logic [W-1:0]                       quo_reg, quo_next;
    logic [gdmm_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [DIVISOR_W:0]                 trial;
    logic                               fits;

    always_comb begin
        trial    = {rem_reg[DIVISOR_W-1:0], quo_reg[W-1]};
        fits     = trial >= {1'b0, divisor};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? (trial - {1'b0, divisor}) : trial;
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == gdmm_pkg::DIV_CNT_W'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/gps_decimator_min_max.sv]
`timescale 1ns / 1ps
// gps_decimator_min_max: decimates GPS samples, averages over each window,
// tracks running extremes. Depends on gdmm_pkg and gdmm_div.
//
// Usage
//   Input channel (s_*): one transaction per GPS sample (s_kind = 0) or per
//   report request (s_kind = 1). s_ready is high only while the sequencer
//   is idle; one item is in work at a time.
//   Result channel (m_*): a due sample gives one record (m_last = 1); a
//   report gives the minimum row then the maximum row (m_last on the second).
//   A sample that is not due gives nothing.
//   Config channel (cfg_*): always ready; index 0 is the period in ms,
//   index 1 the part offset. Write only while the block is idle.
// Sequencing
//   A sample that is not due gives no record; the first sample skips the
//   divider; any other due sample waits for three passes of the 48-step
//   serial divider that forms the altitude and speed averages.
//   Speed conversion to m/h uses one multiplier, one speed per cycle.
// Reset: synchronous, active low; window, extremes and config go to their
//   defaults (period 1000 ms). When the receiver stalls, the output register
//   holds its transaction and the sequencer waits in the emit or report state.
module gps_decimator_min_max #(
    parameter int MAX_WINDOW = 65535
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [31:0]        s_sample_time_ms,
    input  logic signed [30:0] s_latitude,
    input  logic signed [31:0] s_longitude,
    input  logic signed [24:0] s_altitude_mm,
    input  logic [17:0]        s_ground_speed,
    input  logic [17:0]        s_space_speed,
    input  logic [31:0]        s_utc_seconds,
    input  logic [1:0]         s_fix_quality,
    input  logic [13:0]        s_precision_dilution,
    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_record_type,
    output logic signed [30:0] m_out_latitude,
    output logic signed [31:0] m_out_longitude,
    output logic signed [24:0] m_out_altitude_mm,
    output logic [19:0]        m_out_ground_speed,
    output logic [19:0]        m_out_space_speed,
    output logic [31:0]        m_out_utc_seconds,
    output logic [1:0]         m_out_fix_quality,
    output logic [13:0]        m_out_precision_dilution,
    output logic [31:0]        m_drift_ms,
    output logic               m_last
);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = gdmm_pkg::SUM_W;
    localparam int MW = gdmm_pkg::MPH_W;

    gdmm_pkg::state_t state_reg, state_next;

    // configuration
    logic [15:0] period_reg;
    logic [31:0] offset_reg;

    // captured item
    logic [31:0]        tms_reg;
    logic signed [30:0] lat_reg;
    logic signed [31:0] lon_reg;
    logic signed [24:0] alt_reg;
    logic [17:0]        gs_raw_reg, ss_raw_reg;
    logic [31:0]        utc_reg;
    logic [1:0]         fix_reg;
    logic [13:0]        dop_reg;
    logic [MW-1:0]      gs_reg, ss_reg;       // m/h

    // decimation and window state
    logic               have_reg;
    logic               first_reg;
    logic [31:0]        due_reg;
    logic [31:0]        drift_reg;
    logic [CW-1:0]      count_reg;
    logic signed [SW-1:0] alt_sum_reg;
    logic [SW-1:0]      gs_sum_reg, ss_sum_reg;
    logic [13:0]        wdop_reg;

    // averages
    logic               alt_neg_reg;
    logic signed [24:0] avg_alt_reg;
    logic [MW-1:0]      avg_gs_reg, avg_ss_reg;

    // extremes
    logic signed [30:0] lat_min_reg, lat_max_reg;
    logic signed [31:0] lon_min_reg, lon_max_reg;
    logic signed [24:0] alt_min_reg, alt_max_reg;
    logic [MW-1:0]      gs_min_reg, gs_max_reg, ss_min_reg, ss_max_reg;
    logic [31:0]        utc_min_reg, utc_max_reg;
    logic [1:0]         fix_min_reg, fix_max_reg;
    logic [13:0]        dop_min_reg, dop_max_reg;

    // output register
    logic               m_valid_reg;
    logic [1:0]         o_type_reg;
    logic signed [30:0] o_lat_reg;
    logic signed [31:0] o_lon_reg;
    logic signed [24:0] o_alt_reg;
    logic [MW-1:0]      o_gs_reg, o_ss_reg;
    logic [31:0]        o_utc_reg;
    logic [1:0]         o_fix_reg;
    logic [13:0]        o_dop_reg;
    logic [31:0]        o_drift_reg;
    logic               o_last_reg;

    // shared multiplier: speed * 3.6 rounded, via reciprocal of ten
    logic [17:0]                        mul_src;
    logic [gdmm_pkg::MPH_X_W-1:0]       mul_x;
    logic [2*gdmm_pkg::MPH_X_W-1:0]     mul_p;
    logic [MW-1:0]                      mul_q;

    assign mul_src = (state_reg == gdmm_pkg::ST_CONV_GS) ? gs_raw_reg : ss_raw_reg;
    assign mul_x   = ({6'd0, mul_src} << 5) + ({6'd0, mul_src} << 2)
                     + gdmm_pkg::MPH_X_W'(5);
    assign mul_p   = mul_x * gdmm_pkg::RECIP_TEN;
    assign mul_q   = mul_p[gdmm_pkg::RECIP_SHIFT +: MW];

    // timing of the sample
    logic [31:0] t_now;
    logic [32:0] due_half;
    logic        due_now;
    logic [13:0] wdop_upd;

    assign t_now    = tms_reg + offset_reg;
    assign due_half = {1'b0, due_reg} + {18'd0, period_reg[15:1]};
    assign due_now  = !have_reg || (t_now >= due_reg);
    assign wdop_upd = (dop_reg > wdop_reg) ? dop_reg : wdop_reg;

    // divider
    logic          div_start, div_busy, div_done;
    logic [SW-1:0] div_dividend, div_q;
    logic [SW-1:0] alt_mag, half_cnt;

    assign half_cnt = SW'(count_reg >> 1);
    assign alt_mag  = alt_sum_reg[SW-1] ? SW'(-alt_sum_reg) : SW'(alt_sum_reg);

    always_comb begin
        case (state_reg)
            gdmm_pkg::ST_ALT_GO: div_dividend = alt_mag + half_cnt;
            gdmm_pkg::ST_GS_GO:  div_dividend = gs_sum_reg + half_cnt;
            default:             div_dividend = ss_sum_reg + half_cnt;
        endcase
    end

    assign div_start = (state_reg == gdmm_pkg::ST_ALT_GO) ||
                       (state_reg == gdmm_pkg::ST_GS_GO) ||
                       (state_reg == gdmm_pkg::ST_SS_GO);

    gdmm_div #(.DIVISOR_W(CW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gdmm_pkg::ST_IDLE:
                if (s_valid) begin
                    state_next = (s_kind == gdmm_pkg::KIND_REPORT) ?
                                 gdmm_pkg::ST_RPT_MIN : gdmm_pkg::ST_CONV_GS;
                end
            gdmm_pkg::ST_CONV_GS: state_next = gdmm_pkg::ST_CONV_SS;
            gdmm_pkg::ST_CONV_SS: state_next = gdmm_pkg::ST_UPDATE;
            gdmm_pkg::ST_UPDATE: begin
                if (!due_now)       state_next = gdmm_pkg::ST_IDLE;
                else if (!have_reg) state_next = gdmm_pkg::ST_EMIT;
                else                state_next = gdmm_pkg::ST_ALT_GO;
            end
            gdmm_pkg::ST_ALT_GO:  state_next = gdmm_pkg::ST_ALT_WAIT;
            gdmm_pkg::ST_ALT_WAIT: if (div_done) state_next = gdmm_pkg::ST_GS_GO;
            gdmm_pkg::ST_GS_GO:   state_next = gdmm_pkg::ST_GS_WAIT;
            gdmm_pkg::ST_GS_WAIT: if (div_done) state_next = gdmm_pkg::ST_SS_GO;
            gdmm_pkg::ST_SS_GO:   state_next = gdmm_pkg::ST_SS_WAIT;
            gdmm_pkg::ST_SS_WAIT: if (div_done) state_next = gdmm_pkg::ST_EMIT;
            gdmm_pkg::ST_EMIT:    if (out_free) state_next = gdmm_pkg::ST_IDLE;
            gdmm_pkg::ST_RPT_MIN: if (out_free) state_next = gdmm_pkg::ST_RPT_MAX;
            gdmm_pkg::ST_RPT_MAX: if (out_free) state_next = gdmm_pkg::ST_IDLE;
            default:              state_next = gdmm_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    logic out_load;
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            gdmm_pkg::ST_IDLE:    s_ready  = 1'b1;
            gdmm_pkg::ST_EMIT,
            gdmm_pkg::ST_RPT_MIN,
            gdmm_pkg::ST_RPT_MAX: out_load = out_free;
            default: ;
        endcase
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gdmm_pkg::ST_IDLE;
            period_reg  <= 16'd1000;
            offset_reg  <= '0;
            have_reg    <= 1'b0;
            due_reg     <= '0;
            count_reg   <= '0;
            alt_sum_reg <= '0;
            gs_sum_reg  <= '0;
            ss_sum_reg  <= '0;
            wdop_reg    <= '0;
            lat_min_reg <= '0; lat_max_reg <= '0;
            lon_min_reg <= '0; lon_max_reg <= '0;
            alt_min_reg <= '0; alt_max_reg <= '0;
            gs_min_reg  <= '0; gs_max_reg  <= '0;
            ss_min_reg  <= '0; ss_max_reg  <= '0;
            utc_min_reg <= gdmm_pkg::TIME_INVALID;
            utc_max_reg <= gdmm_pkg::TIME_INVALID;
            fix_min_reg <= '0; fix_max_reg <= '0;
            dop_min_reg <= '0; dop_max_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gdmm_pkg::CFG_PERIOD: period_reg <= cfg_data[15:0];
                    gdmm_pkg::CFG_OFFSET: offset_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == gdmm_pkg::ST_UPDATE) begin
                wdop_reg <= wdop_upd;
                if (!have_reg) begin
                    lat_min_reg <= lat_reg;    lat_max_reg <= lat_reg;
                    lon_min_reg <= lon_reg;    lon_max_reg <= lon_reg;
                    alt_min_reg <= alt_reg;    alt_max_reg <= alt_reg;
                    gs_min_reg  <= gs_reg;     gs_max_reg  <= gs_reg;
                    ss_min_reg  <= ss_reg;     ss_max_reg  <= ss_reg;
                    utc_min_reg <= utc_reg;    utc_max_reg <= utc_reg;
                    fix_min_reg <= fix_reg;    fix_max_reg <= fix_reg;
                    dop_min_reg <= dop_reg;    dop_max_reg <= dop_reg;
                end else begin
                    if (lat_reg < lat_min_reg) lat_min_reg <= lat_reg;
                    if (lat_reg > lat_max_reg) lat_max_reg <= lat_reg;
                    if (lon_reg < lon_min_reg) lon_min_reg <= lon_reg;
                    if (lon_reg > lon_max_reg) lon_max_reg <= lon_reg;
                    if (alt_reg < alt_min_reg) alt_min_reg <= alt_reg;
                    if (alt_reg > alt_max_reg) alt_max_reg <= alt_reg;
                    if (gs_reg < gs_min_reg)   gs_min_reg  <= gs_reg;
                    if (gs_reg > gs_max_reg)   gs_max_reg  <= gs_reg;
                    if (ss_reg < ss_min_reg)   ss_min_reg  <= ss_reg;
                    if (ss_reg > ss_max_reg)   ss_max_reg  <= ss_reg;
                    // past the first sample, invalid UTC never enters the time extremes
                    if (utc_reg != gdmm_pkg::TIME_INVALID) begin
                        if (utc_min_reg == gdmm_pkg::TIME_INVALID || utc_min_reg > utc_reg)
                            utc_min_reg <= utc_reg;
                        if (utc_max_reg == gdmm_pkg::TIME_INVALID || utc_max_reg < utc_reg)
                            utc_max_reg <= utc_reg;
                    end
                    if (fix_reg < fix_min_reg) fix_min_reg <= fix_reg;
                    if (fix_reg > fix_max_reg) fix_max_reg <= fix_reg;
                    if (dop_reg < dop_min_reg) dop_min_reg <= dop_reg;
                    if (dop_reg > dop_max_reg) dop_max_reg <= dop_reg;
                end

                if (due_now) begin
                    due_reg <= due_reg + {16'd0, period_reg};
                end else if (count_reg < CW'(MAX_WINDOW)) begin
                    count_reg   <= count_reg + 1'b1;
                    alt_sum_reg <= alt_sum_reg + SW'(alt_reg);
                    gs_sum_reg  <= gs_sum_reg + SW'(gs_reg);
                    ss_sum_reg  <= ss_sum_reg + SW'(ss_reg);
                end
            end

            // record goes out: window restarts holding this sample
            if (state_reg == gdmm_pkg::ST_EMIT && out_free) begin
                have_reg    <= 1'b1;
                wdop_reg    <= '0;
                count_reg   <= CW'(1);
                alt_sum_reg <= SW'(alt_reg);
                gs_sum_reg  <= SW'(gs_reg);
                ss_sum_reg  <= SW'(ss_reg);
            end

            if (out_load)               m_valid_reg <= 1'b1;
            else if (m_ready)           m_valid_reg <= 1'b0;
        end

        // payload registers
        if (s_valid && s_ready) begin
            tms_reg    <= s_sample_time_ms;
            lat_reg    <= s_latitude;
            lon_reg    <= s_longitude;
            alt_reg    <= s_altitude_mm;
            gs_raw_reg <= s_ground_speed;
            ss_raw_reg <= s_space_speed;
            utc_reg    <= s_utc_seconds;
            fix_reg    <= s_fix_quality;
            dop_reg    <= s_precision_dilution;
        end
        if (state_reg == gdmm_pkg::ST_CONV_GS) gs_reg <= mul_q;
        if (state_reg == gdmm_pkg::ST_CONV_SS) ss_reg <= mul_q;
        if (state_reg == gdmm_pkg::ST_UPDATE) begin
            first_reg   <= !have_reg;
            alt_neg_reg <= alt_sum_reg[SW-1];
            drift_reg   <= (have_reg && ({1'b0, t_now} > due_half)) ?
                           32'({1'b0, t_now} - due_half) : 32'd0;
        end
        if (state_reg == gdmm_pkg::ST_ALT_WAIT && div_done)
            avg_alt_reg <= alt_neg_reg ? -$signed(div_q[24:0]) : $signed(div_q[24:0]);
        if (state_reg == gdmm_pkg::ST_GS_WAIT && div_done) avg_gs_reg <= div_q[MW-1:0];
        if (state_reg == gdmm_pkg::ST_SS_WAIT && div_done) avg_ss_reg <= div_q[MW-1:0];

        if (out_load) begin
            case (state_reg)
                gdmm_pkg::ST_RPT_MIN: begin
                    o_type_reg  <= gdmm_pkg::REC_MIN;
                    o_lat_reg   <= lat_min_reg;  o_lon_reg <= lon_min_reg;
                    o_alt_reg   <= alt_min_reg;
                    o_gs_reg    <= gs_min_reg;   o_ss_reg  <= ss_min_reg;
                    o_utc_reg   <= utc_min_reg;  o_fix_reg <= fix_min_reg;
                    o_dop_reg   <= dop_min_reg;
                    o_drift_reg <= '0;           o_last_reg <= 1'b0;
                end
                gdmm_pkg::ST_RPT_MAX: begin
                    o_type_reg  <= gdmm_pkg::REC_MAX;
                    o_lat_reg   <= lat_max_reg;  o_lon_reg <= lon_max_reg;
                    o_alt_reg   <= alt_max_reg;
                    o_gs_reg    <= gs_max_reg;   o_ss_reg  <= ss_max_reg;
                    o_utc_reg   <= utc_max_reg;  o_fix_reg <= fix_max_reg;
                    o_dop_reg   <= dop_max_reg;
                    o_drift_reg <= '0;           o_last_reg <= 1'b1;
                end
                default: begin
                    o_type_reg  <= gdmm_pkg::REC_SAMPLE;
                    o_lat_reg   <= lat_reg;      o_lon_reg <= lon_reg;
                    o_alt_reg   <= first_reg ? alt_reg : avg_alt_reg;
                    o_gs_reg    <= first_reg ? gs_reg : avg_gs_reg;
                    o_ss_reg    <= first_reg ? ss_reg : avg_ss_reg;
                    o_utc_reg   <= utc_reg;      o_fix_reg <= fix_reg;
                    o_dop_reg   <= wdop_reg;
                    o_drift_reg <= drift_reg;    o_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_valid                  = m_valid_reg;
    assign m_record_type            = o_type_reg;
    assign m_out_latitude           = o_lat_reg;
    assign m_out_longitude          = o_lon_reg;
    assign m_out_altitude_mm        = o_alt_reg;
    assign m_out_ground_speed       = o_gs_reg;
    assign m_out_space_speed        = o_ss_reg;
    assign m_out_utc_seconds        = o_utc_reg;
    assign m_out_fix_quality        = o_fix_reg;
    assign m_out_precision_dilution = o_dop_reg;
    assign m_drift_ms               = o_drift_reg;
    assign m_last                   = o_last_reg;

`ifndef SYNTHESIS
    a_div_idle_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_busy)
        else $error("divider busy while accepting input");
    a_min_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_record_type == gdmm_pkg::REC_MIN) |-> !m_last)
        else $error("minimum row marked last");
    a_sample_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_record_type == gdmm_pkg::REC_SAMPLE) |-> m_last)
        else $error("stored record not marked last");
    a_first_no_drift: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gdmm_pkg::ST_UPDATE && !have_reg) |=> drift_reg == 32'd0)
        else $error("drift on first record");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for gps_decimator_min_max with a record scoreboard.
// Depends on gdmm_pkg and the DUT sources.
module tb_top;

    localparam int WIN_MAX = 65535;
    localparam int WATCHDOG = 20000;

    // one result transaction as seen on the m_* port
    typedef struct packed {
        logic [1:0]         rtype;
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        logic signed [24:0] alt;
        logic [19:0]        gs;
        logic [19:0]        ss;
        logic [31:0]        utc;
        logic [1:0]         fix;
        logic [13:0]        dop;
        logic [31:0]        drift;
        logic               last;
    } gps_rec_t;

    // scoreboard: own copy of decimator state, predicts records per input
    class gps_record_board;
        gps_rec_t      pending[$];
        int            errors;
        logic [15:0]   period;
        logic [31:0]   offset;
        bit            have_rec;
        logic [31:0]   next_due;
        int unsigned   win_cnt;
        longint        alt_sum;
        longint        gs_sum;
        longint        ss_sum;
        int unsigned   win_dop;
        int            lat_mn, lat_mx, lon_mn, lon_mx, alt_mn, alt_mx;
        int            gs_mn, gs_mx, ss_mn, ss_mx;
        logic [31:0]   utc_mn, utc_mx;
        int unsigned   fix_mn, fix_mx, dop_mn, dop_mx;

        function new();
            errors = 0;
            period = 16'd1000; offset = 0;
            have_rec = 0; next_due = 0; win_cnt = 0;
            alt_sum = 0; gs_sum = 0; ss_sum = 0; win_dop = 0;
            lat_mn = 0; lat_mx = 0; lon_mn = 0; lon_mx = 0; alt_mn = 0; alt_mx = 0;
            gs_mn = 0; gs_mx = 0; ss_mn = 0; ss_mx = 0;
            utc_mn = gdmm_pkg::TIME_INVALID; utc_mx = gdmm_pkg::TIME_INVALID;
            fix_mn = 0; fix_mx = 0; dop_mn = 0; dop_mx = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == gdmm_pkg::CFG_PERIOD) period = val[15:0];
            else if (idx == gdmm_pkg::CFG_OFFSET) offset = val;
        endfunction

        static function int mph(logic [17:0] v);
            return (int'(v) * 36 + 5) / 10;
        endfunction

        static function longint round_div(longint s, int unsigned n);
            if (n == 0) return 0;
            if (s < 0) return -(((-s) + n / 2) / n);
            return (s + n / 2) / n;
        endfunction

        function void note_item(logic kind, logic [31:0] tms, logic signed [30:0] lat,
                                logic signed [31:0] lon, logic signed [24:0] alt,
                                logic [17:0] gsr, logic [17:0] ssr, logic [31:0] utc,
                                logic [1:0] fix, logic [13:0] dop);
            gps_rec_t r;
            int gs, ss;
            logic [31:0] t;
            logic [32:0] lim;
            logic [31:0] drift;
            gs = mph(gsr); ss = mph(ssr);
            if (kind == gdmm_pkg::KIND_REPORT) begin
                r = '{gdmm_pkg::REC_MIN, 31'(lat_mn), 32'(lon_mn), 25'(alt_mn),
                      20'(gs_mn), 20'(ss_mn), utc_mn, 2'(fix_mn), 14'(dop_mn),
                      32'd0, 1'b0};
                pending = {pending, r};
                r = '{gdmm_pkg::REC_MAX, 31'(lat_mx), 32'(lon_mx), 25'(alt_mx),
                      20'(gs_mx), 20'(ss_mx), utc_mx, 2'(fix_mx), 14'(dop_mx),
                      32'd0, 1'b1};
                pending = {pending, r};
                return;
            end
            if (dop > win_dop) win_dop = dop;
            if (!have_rec) begin
                lat_mn = lat; lat_mx = lat; lon_mn = lon; lon_mx = lon;
                alt_mn = alt; alt_mx = alt; gs_mn = gs; gs_mx = gs;
                ss_mn = ss; ss_mx = ss; utc_mn = utc; utc_mx = utc;
                fix_mn = fix; fix_mx = fix; dop_mn = dop; dop_mx = dop;
            end else begin
                if (lat < lat_mn) lat_mn = lat;
                if (lat > lat_mx) lat_mx = lat;
                if (lon < lon_mn) lon_mn = lon;
                if (lon > lon_mx) lon_mx = lon;
                if (alt < alt_mn) alt_mn = alt;
                if (alt > alt_mx) alt_mx = alt;
                if (gs < gs_mn) gs_mn = gs;
                if (gs > gs_mx) gs_mx = gs;
                if (ss < ss_mn) ss_mn = ss;
                if (ss > ss_mx) ss_mx = ss;
                // past the first sample, invalid time never enters the extremes
                if (utc != gdmm_pkg::TIME_INVALID) begin
                    if (utc_mn == gdmm_pkg::TIME_INVALID || utc_mn > utc) utc_mn = utc;
                    if (utc_mx == gdmm_pkg::TIME_INVALID || utc_mx < utc) utc_mx = utc;
                end
                if (fix < fix_mn) fix_mn = fix;
                if (fix > fix_mx) fix_mx = fix;
                if (dop < dop_mn) dop_mn = dop;
                if (dop > dop_mx) dop_mx = dop;
            end
            t = tms + offset;
            if (have_rec && t < next_due) begin
                if (win_cnt < WIN_MAX) begin
                    win_cnt++; alt_sum += alt; gs_sum += gs; ss_sum += ss;
                end
                return;
            end
            lim = {1'b0, next_due} + 33'(period / 2);
            drift = ({1'b0, t} > lim) ? 32'({1'b0, t} - lim) : 32'd0;
            next_due = next_due + 32'(period);
            if (!have_rec)
                r = '{gdmm_pkg::REC_SAMPLE, lat, lon, alt, 20'(gs), 20'(ss), utc, fix,
                      14'(win_dop), 32'd0, 1'b1};
            else
                r = '{gdmm_pkg::REC_SAMPLE, lat, lon, 25'(round_div(alt_sum, win_cnt)),
                      20'(round_div(gs_sum, win_cnt)), 20'(round_div(ss_sum, win_cnt)),
                      utc, fix, 14'(win_dop), drift, 1'b1};
            pending = {pending, r};
            have_rec = 1; win_dop = 0; win_cnt = 1;
            alt_sum = alt; gs_sum = gs; ss_sum = ss;
        endfunction

        function void check_record(gps_rec_t got);
            gps_rec_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transaction, type %0d", got.rtype);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.rtype !== e.rtype) begin
                $error("record_type exp %0d got %0d", e.rtype, got.rtype); errors++;
            end
            if (got.lat !== e.lat) begin
                $error("out_latitude exp %0d got %0d", e.lat, got.lat); errors++;
            end
            if (got.lon !== e.lon) begin
                $error("out_longitude exp %0d got %0d", e.lon, got.lon); errors++;
            end
            if (got.alt !== e.alt) begin
                $error("out_altitude_mm exp %0d got %0d", e.alt, got.alt); errors++;
            end
            if (got.gs !== e.gs) begin
                $error("out_ground_speed exp %0d got %0d", e.gs, got.gs); errors++;
            end
            if (got.ss !== e.ss) begin
                $error("out_space_speed exp %0d got %0d", e.ss, got.ss); errors++;
            end
            if (got.utc !== e.utc) begin
                $error("out_utc_seconds exp %0h got %0h", e.utc, got.utc); errors++;
            end
            if (got.fix !== e.fix) begin
                $error("out_fix_quality exp %0d got %0d", e.fix, got.fix); errors++;
            end
            if (got.dop !== e.dop) begin
                $error("out_precision_dilution exp %0d got %0d", e.dop, got.dop);
                errors++;
            end
            if (got.drift !== e.drift) begin
                $error("drift_ms exp %0d got %0d", e.drift, got.drift); errors++;
            end
            if (got.last !== e.last) begin
                $error("last exp %0d got %0d", e.last, got.last); errors++;
            end
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = 0;
    logic [31:0]        cfg_data = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic               s_kind = 0;
    logic [31:0]        s_sample_time_ms = 0;
    logic signed [30:0] s_latitude = 0;
    logic signed [31:0] s_longitude = 0;
    logic signed [24:0] s_altitude_mm = 0;
    logic [17:0]        s_ground_speed = 0;
    logic [17:0]        s_space_speed = 0;
    logic [31:0]        s_utc_seconds = 0;
    logic [1:0]         s_fix_quality = 0;
    logic [13:0]        s_precision_dilution = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [1:0]         m_record_type;
    logic signed [30:0] m_out_latitude;
    logic signed [31:0] m_out_longitude;
    logic signed [24:0] m_out_altitude_mm;
    logic [19:0]        m_out_ground_speed;
    logic [19:0]        m_out_space_speed;
    logic [31:0]        m_out_utc_seconds;
    logic [1:0]         m_out_fix_quality;
    logic [13:0]        m_out_precision_dilution;
    logic [31:0]        m_drift_ms;
    logic               m_last;

    gps_decimator_min_max DUT (.*);

    gps_record_board board = new();

    // idle percentages per phase; hold_recv forces a long receiver stall
    int  send_idle_pct = 30;
    int  recv_idle_pct = 70;
    bit  hold_recv = 0;
    int  idle_cycles = 0;
    logic [31:0] sim_t = 0;     // running sample clock in ms

    initial begin
        forever #2 aclk = ~aclk;
    end

    // watchdog: any cycle with no transaction on any channel counts
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (aresetn)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: sample at rising edge, change ready at falling edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_record('{m_record_type, m_out_latitude, m_out_longitude,
                m_out_altitude_mm, m_out_ground_speed, m_out_space_speed,
                m_out_utc_seconds, m_out_fix_quality, m_out_precision_dilution,
                m_drift_ms, m_last});
    end

    always @(negedge aclk) begin
        m_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end

    // config write: only called while the block is idle
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    // present one item and hold it until the transaction completes;
    // valid stays up into the next item when the sender does not idle
    task automatic send_item(logic kind, logic [31:0] tms, logic signed [30:0] lat,
                             logic signed [31:0] lon, logic signed [24:0] alt,
                             logic [17:0] gs, logic [17:0] ss, logic [31:0] utc,
                             logic [1:0] fix, logic [13:0] dop);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1; s_kind <= kind; s_sample_time_ms <= tms;
        s_latitude <= lat; s_longitude <= lon; s_altitude_mm <= alt;
        s_ground_speed <= gs; s_space_speed <= ss; s_utc_seconds <= utc;
        s_fix_quality <= fix; s_precision_dilution <= dop;
        do @(posedge aclk); while (!s_ready);
        board.note_item(kind, tms, lat, lon, alt, gs, ss, utc, fix, dop);
        @(negedge aclk);
    endtask

    // random GPS sample; mostly in-range fields, time stepping forward
    task automatic send_sample(int step_ms);
        logic [31:0] utc;
        sim_t = sim_t + step_ms;
        utc = ($urandom_range(9) == 0) ? gdmm_pkg::TIME_INVALID : $urandom();
        if ($urandom_range(3) == 0)
            send_item(gdmm_pkg::KIND_SAMPLE, $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom(), utc, $urandom(), $urandom());
        else
            send_item(gdmm_pkg::KIND_SAMPLE, sim_t, $urandom_range(1800000000) - 900000000,
                      $urandom_range(2000000000) - 1000000000,
                      $urandom_range(10500000) - 500000, $urandom_range(200000),
                      $urandom_range(200000), utc, $urandom_range(3),
                      $urandom_range(9999));
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(negedge aclk);
        // a not-due sample yields nothing; let the sequencer settle
        repeat (200) @(negedge aclk);
    endtask

    task automatic random_phase(int n, int max_step);
        repeat (n) begin
            if ($urandom_range(15) == 0)
                send_item(gdmm_pkg::KIND_REPORT, $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom());
            else
                send_sample($urandom_range(max_step));
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: report before any sample shows reset extremes
        send_item(gdmm_pkg::KIND_REPORT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // first sample with invalid time still seeds time extremes
        send_item(gdmm_pkg::KIND_SAMPLE, 0, -900000000, 1800000000, 10000000, 200000, 0,
                  gdmm_pkg::TIME_INVALID, 3, 9999);
        send_item(gdmm_pkg::KIND_SAMPLE, 10, 900000000, -1800000000, -500000, 0, 200000,
                  32'd5, 0, 0);
        send_item(gdmm_pkg::KIND_SAMPLE, 20, 31'h3FFFFFFF, 32'h7FFFFFFF, 25'hFFFFFF,
                  18'h3FFFF, 18'h3FFFF, 32'hFFFFFFFE, 1, 14'h3FFF);
        send_item(gdmm_pkg::KIND_SAMPLE, 30, 31'h40000000, 32'h80000000, 25'h1000000, 1, 3,
                  gdmm_pkg::TIME_INVALID, 2, 1);
        send_item(gdmm_pkg::KIND_REPORT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // late sample: drift beyond half a period
        send_item(gdmm_pkg::KIND_SAMPLE, 5000, -1, -1, -3, 7, 9, 100, 3, 50);
        send_item(gdmm_pkg::KIND_SAMPLE, 5999, 1, 1, -2, 6, 8, 101, 3, 60);
        send_item(gdmm_pkg::KIND_SAMPLE, 6000, 2, 2, 1, 5, 4, 102, 2, 40);
        drain();

        // zero period: every sample past next_due is emitted
        write_reg(gdmm_pkg::CFG_PERIOD, 32'd0);
        write_reg(gdmm_pkg::CFG_OFFSET, 32'hFFFFFFFF);
        send_item(gdmm_pkg::KIND_SAMPLE, 32'd7000, 10, 10, 10, 10, 10, 200, 3, 10);
        send_item(gdmm_pkg::KIND_SAMPLE, 32'd7000, 11, 11, 11, 11, 11, 201, 3, 11);
        send_item(gdmm_pkg::KIND_REPORT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // phase 1: sender 30%, receiver 70%, short period
        write_reg(gdmm_pkg::CFG_PERIOD, 32'd1);
        write_reg(gdmm_pkg::CFG_OFFSET, 32'd0);
        sim_t = 32'd10000;
        random_phase(120, 3);

        // long receiver stall while the sender keeps offering items
        fork
            begin
                hold_recv = 1;
                repeat (600) @(posedge aclk);
                hold_recv = 0;
            end
            random_phase(10, 3);
        join
        drain();

        // phase 2: swapped idling, longer period and wrapping offset
        send_idle_pct = 70; recv_idle_pct = 30;
        write_reg(gdmm_pkg::CFG_PERIOD, 32'd60000);
        write_reg(gdmm_pkg::CFG_OFFSET, 32'hFFFF0000);
        random_phase(150, 9000);
        drain();

        // phase 3: no idling, max period, then a period of 100 ms
        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(gdmm_pkg::CFG_PERIOD, 32'hFFFF);
        write_reg(gdmm_pkg::CFG_OFFSET, $urandom());
        random_phase(50, 40000);
        drain();
        write_reg(gdmm_pkg::CFG_PERIOD, 32'd100);
        random_phase(120, 60);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

[files.f]
rtl/gdmm_pkg.sv
rtl/gdmm_div.sv
rtl/gps_decimator_min_max.sv
tb/tb_top.sv
